// ===== rtl/core/halfspace_row_normalizer_macros.svh =====
// Assertion helpers for the halfspace row normalizer.
`ifndef HALFSPACE_ROW_NORMALIZER_MACROS_SVH
`define HALFSPACE_ROW_NORMALIZER_MACROS_SVH

// Implication in the same cycle.
`define HSRN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent a fixed number of cycles later.
`define HSRN_ASSERT_LAT(label, clk, rst_n, ante, lat, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##lat (cons)) \
    else $error("latency assertion failed");

`endif

// ===== rtl/core/hsrn_pkg.sv =====
package hsrn_pkg;

  localparam int COEF_N      = 6;
  localparam int LANE_N      = 7;
  localparam int SQRT_STAGES = 34;
  localparam int DIV_BITS    = 32;
  localparam int NORM_W      = 34;
  localparam int RAD_W       = 68;
  localparam int REM_W       = 37;
  localparam int DREM_W      = 35;
  localparam logic [6:0] HORIZON_RESET = 7'd64;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic                        status;
    logic [5:0]                  knot;
    logic [2:0]                  plane;
    logic                        en;
    logic [30:0]                 pen;
    logic [LANE_N-1:0]           neg;
    logic [LANE_N-1:0][31:0]     mag;
  } side_t;

endpackage

// ===== rtl/core/hsrn_sqsum.sv =====
module hsrn_sqsum (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  hsrn_pkg::side_t       in_sb,
  output logic                  out_valid,
  output hsrn_pkg::side_t       out_sb,
  output logic [65:0]           out_sum
);

  logic [2:0]                          v_r;
  hsrn_pkg::side_t                     sb1_r, sb2_r, sb3_r;
  logic [hsrn_pkg::COEF_N-1:0][63:0]   sq_r;
  logic [2:0][64:0]                    pair_r;
  logic [65:0]                         sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < hsrn_pkg::COEF_N; i++) begin
      sq_r[i] <= in_sb.mag[i] * in_sb.mag[i];
    end
    sb1_r <= in_sb;
    for (int i = 0; i < 3; i++) begin
      pair_r[i] <= {1'b0, sq_r[2*i]} + {1'b0, sq_r[2*i+1]};
    end
    sb2_r <= sb1_r;
    sum_r <= {1'b0, pair_r[0]} + {1'b0, pair_r[1]} + {1'b0, pair_r[2]};
    sb3_r <= sb2_r;
  end

  assign out_valid = v_r[2];
  assign out_sb    = sb3_r;
  assign out_sum   = sum_r;

endmodule

// ===== rtl/core/hsrn_sqrt.sv =====
// Digit-by-digit square root, one root bit per stage.
module hsrn_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  hsrn_pkg::side_t               in_sb,
  input  logic [65:0]                   in_sum,
  output logic                          out_valid,
  output hsrn_pkg::side_t               out_sb,
  output logic [hsrn_pkg::NORM_W-1:0]   out_root
);

  localparam int N = hsrn_pkg::SQRT_STAGES;

  logic                            v_r    [N+1];
  hsrn_pkg::side_t                 sb_r   [N+1];
  logic [hsrn_pkg::RAD_W-1:0]      rad_r  [N+1];
  logic [hsrn_pkg::REM_W-1:0]      rem_r  [N+1];
  logic [hsrn_pkg::NORM_W-1:0]     root_r [N+1];

  always_comb begin
    v_r[0]    = in_valid;
    sb_r[0]   = in_sb;
    rad_r[0]  = {2'b00, in_sum};
    rem_r[0]  = '0;
    root_r[0] = '0;
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [hsrn_pkg::REM_W-1:0] cur;
    logic [hsrn_pkg::REM_W-1:0] trial;

    always_comb begin
      cur   = {rem_r[g][hsrn_pkg::REM_W-3:0], rad_r[g][hsrn_pkg::RAD_W-1-2*g -: 2]};
      trial = {1'b0, root_r[g], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      sb_r[g+1]  <= sb_r[g];
      rad_r[g+1] <= rad_r[g];
      if (cur >= trial) begin
        rem_r[g+1]  <= cur - trial;
        root_r[g+1] <= {root_r[g][hsrn_pkg::NORM_W-2:0], 1'b1};
      end else begin
        rem_r[g+1]  <= cur;
        root_r[g+1] <= {root_r[g][hsrn_pkg::NORM_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = v_r[N];
  assign out_sb    = sb_r[N];
  assign out_root  = root_r[N];

endmodule

// ===== rtl/core/hsrn_div.sv =====
// Seven restoring dividers in lockstep: overflow check, then one quotient bit per stage.
module hsrn_div (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  hsrn_pkg::side_t                         in_sb,
  input  logic [hsrn_pkg::NORM_W-1:0]             in_norm,
  output logic                                    out_valid,
  output hsrn_pkg::side_t                         out_sb,
  output logic [hsrn_pkg::LANE_N-1:0][31:0]       out_q,
  output logic [hsrn_pkg::LANE_N-1:0]             out_ovf
);

  localparam int N = hsrn_pkg::DIV_BITS;
  localparam int L = hsrn_pkg::LANE_N;
  localparam int W = hsrn_pkg::DREM_W;

  logic                         v_r    [N+1];
  hsrn_pkg::side_t              sb_r   [N+1];
  logic [hsrn_pkg::NORM_W-1:0]  norm_r [N+1];
  logic [L-1:0][W-1:0]          rem_r  [N+1];
  logic [L-1:0][31:0]           q_r    [N+1];
  logic [L-1:0]                 ovf_r  [N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sb_r[0]   <= in_sb;
    norm_r[0] <= in_norm;
    for (int l = 0; l < L; l++) begin
      ovf_r[0][l] <= {18'd0, in_sb.mag[l][31:16]} >= in_norm;
      rem_r[0][l] <= {19'd0, in_sb.mag[l][31:16]};
      q_r[0][l]   <= '0;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [L-1:0][W-1:0] cur;

    always_comb begin
      for (int l = 0; l < L; l++) begin
        if (g < 16) begin
          cur[l] = {rem_r[g][l][W-2:0], sb_r[g].mag[l][(g < 16) ? 15-g : 0]};
        end else begin
          cur[l] = {rem_r[g][l][W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      sb_r[g+1]   <= sb_r[g];
      norm_r[g+1] <= norm_r[g];
      ovf_r[g+1]  <= ovf_r[g];
      for (int l = 0; l < L; l++) begin
        if (cur[l] >= {1'b0, norm_r[g]}) begin
          rem_r[g+1][l] <= cur[l] - {1'b0, norm_r[g]};
          q_r[g+1][l]   <= {q_r[g][l][30:0], 1'b1};
        end else begin
          rem_r[g+1][l] <= cur[l];
          q_r[g+1][l]   <= {q_r[g][l][30:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_r[N];
  assign out_sb    = sb_r[N];
  assign out_q     = q_r[N];
  assign out_ovf   = ovf_r[N];

endmodule

// ===== rtl/core/halfspace_row_normalizer.sv =====
// Halfspace row normalizer. One row per clock. From the start edge to the
// out_valid strobe, a row runs through a pipeline formed by the square root
// (34 stages, one root bit each) and the seven parallel dividers (one overflow
// stage plus 32 quotient stages), with four stages in front for range check,
// squares and the sum tree, and one output register. busy never rises and the
// result is shown for one cycle only: the receiver must take every strobe.
// cfg_ready is always high; write horizon_length while no row is in flight.
`include "halfspace_row_normalizer_macros.svh"

module halfspace_row_normalizer #(
  parameter int MAX_KNOTS       = 64,
  parameter int PLANES_PER_KNOT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // config write transaction
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data,
  // input transaction
  input  logic               start,
  output logic               busy,
  input  logic signed [7:0]  in_knot,
  input  logic signed [7:0]  in_plane,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic signed [31:0] in_offset,
  input  logic signed [31:0] in_penalty,
  input  logic               in_enable,
  // result transaction
  output logic               out_valid,
  output logic               out_status,
  output logic [5:0]         out_row_knot,
  output logic [2:0]         out_row_plane,
  output logic               out_row_enabled,
  output logic signed [31:0] out_norm_pos_x,
  output logic signed [31:0] out_norm_pos_y,
  output logic signed [31:0] out_norm_pos_z,
  output logic signed [31:0] out_norm_vel_x,
  output logic signed [31:0] out_norm_vel_y,
  output logic signed [31:0] out_norm_vel_z,
  output logic signed [31:0] out_norm_offset,
  output logic [30:0]        out_clamped_penalty
);

  localparam int L   = hsrn_pkg::LANE_N;
  localparam int LAT = 1 + 3 + hsrn_pkg::SQRT_STAGES + 1 + hsrn_pkg::DIV_BITS + 1;

  logic [6:0] horizon_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;   // fully pipelined, no back pressure

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_r <= hsrn_pkg::HORIZON_RESET;
    end else if (cfg_valid && cfg_ready) begin
      horizon_r <= cfg_data;
    end
  end

  // ---- stage 0: range check, magnitudes, signs
  logic [L-1:0][31:0] coef;
  logic [L-1:0][31:0] mag;
  logic [L-1:0]       neg;
  logic               in_range, nonzero;
  hsrn_pkg::side_t    sb0_nxt, sb0_r;
  logic               v0_r;

  always_comb begin
    coef[0] = in_pos_x;
    coef[1] = in_pos_y;
    coef[2] = in_pos_z;
    coef[3] = in_vel_x;
    coef[4] = in_vel_y;
    coef[5] = in_vel_z;
    coef[6] = in_offset;
    for (int l = 0; l < L; l++) begin
      neg[l] = coef[l][31];
      mag[l] = coef[l][31] ? (32'd0 - coef[l]) : coef[l];
    end
    nonzero = 1'b0;
    for (int l = 0; l < hsrn_pkg::COEF_N; l++) begin
      nonzero = nonzero | (coef[l] != 32'd0);
    end
    in_range = !in_knot[7] && !in_plane[7]
            && ({1'b0, in_knot[6:0]} < {1'b0, horizon_r})
            && ({1'b0, in_knot[6:0]} < 8'(MAX_KNOTS))
            && ({1'b0, in_plane[6:0]} < 8'(PLANES_PER_KNOT));
    sb0_nxt.status = in_range ? hsrn_pkg::STATUS_OK : hsrn_pkg::STATUS_RANGE;
    sb0_nxt.knot   = in_range ? in_knot[5:0] : 6'd0;
    sb0_nxt.plane  = in_range ? in_plane[2:0] : 3'd0;
    sb0_nxt.en     = in_range && in_enable && nonzero;
    sb0_nxt.pen    = in_penalty[31] ? 31'd0 : in_penalty[30:0];
    sb0_nxt.neg    = neg;
    sb0_nxt.mag    = mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    sb0_r <= sb0_nxt;
  end

  // ---- sum of squares, square root, division
  logic                         v3, vs, vd;
  hsrn_pkg::side_t              sb3, sbs, sbd;
  logic [65:0]                  sum3;
  logic [hsrn_pkg::NORM_W-1:0]  root;
  logic [L-1:0][31:0]           q;
  logic [L-1:0]                 ovf;

  hsrn_sqsum u_sqsum (
    .clk(clk), .rst_n(rst_n), .in_valid(v0_r), .in_sb(sb0_r),
    .out_valid(v3), .out_sb(sb3), .out_sum(sum3)
  );

  hsrn_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .in_valid(v3), .in_sb(sb3), .in_sum(sum3),
    .out_valid(vs), .out_sb(sbs), .out_root(root)
  );

  hsrn_div u_div (
    .clk(clk), .rst_n(rst_n), .in_valid(vs), .in_sb(sbs), .in_norm(root),
    .out_valid(vd), .out_sb(sbd), .out_q(q), .out_ovf(ovf)
  );

  // ---- saturation, zeroing of disabled rows, output register
  logic [L-1:0][31:0] res_nxt;
  logic [L-1:0][31:0] res_r;
  logic               ov_r, st_r, en_r;
  logic [5:0]         kn_r;
  logic [2:0]         pl_r;
  logic [30:0]        pen_r;

  always_comb begin
    for (int l = 0; l < L; l++) begin
      if (!sbd.en) begin
        res_nxt[l] = '0;
      end else if (sbd.neg[l]) begin
        res_nxt[l] = (ovf[l] || (q[l] > 32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - q[l]);
      end else begin
        res_nxt[l] = (ovf[l] || q[l][31]) ? 32'h7FFF_FFFF : q[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    st_r  <= sbd.status;
    en_r  <= sbd.en;
    kn_r  <= sbd.knot;
    pl_r  <= sbd.plane;
    pen_r <= sbd.en ? sbd.pen : 31'd0;
  end

  assign out_valid           = ov_r;
  assign out_status          = st_r;
  assign out_row_knot        = kn_r;
  assign out_row_plane       = pl_r;
  assign out_row_enabled     = en_r;
  assign out_norm_pos_x      = res_r[0];
  assign out_norm_pos_y      = res_r[1];
  assign out_norm_pos_z      = res_r[2];
  assign out_norm_vel_x      = res_r[3];
  assign out_norm_vel_y      = res_r[4];
  assign out_norm_vel_z      = res_r[5];
  assign out_norm_offset     = res_r[6];
  assign out_clamped_penalty = pen_r;

  // rejected rows carry nothing but the status
  `HSRN_ASSERT_NOW(a_reject_clear, clk, rst_n, out_valid && out_status, !out_row_enabled && out_row_knot == 6'd0 && out_clamped_penalty == 31'd0)
  // disabled rows are zeroed
  `HSRN_ASSERT_NOW(a_disabled_zero, clk, rst_n, out_valid && !out_row_enabled, out_norm_pos_x == 32'd0 && out_norm_offset == 32'd0 && out_clamped_penalty == 31'd0)
  // negative knot index comes out as a reject after the full latency
  `HSRN_ASSERT_LAT(a_reject_latency, clk, rst_n, start && !busy && in_knot[7], LAT, out_valid && out_status)

endmodule

// ===== test/tb_halfspace_row_normalizer.sv =====
`timescale 1ns / 100ps

module tb_halfspace_row_normalizer;

  // one normalized row as the block presents it
  typedef struct {
    logic        status;
    logic [5:0]  knot;
    logic [2:0]  plane;
    logic        en;
    logic [31:0] nv [7];
    logic [30:0] pen;
  } row_t;

  // scoreboard: predicts each accepted row and matches strobed results in order
  class row_scoreboard;
    row_t        pending[$];
    logic [6:0]  horizon;
    int          mismatches;

    function new();
      horizon = hsrn_pkg::HORIZON_RESET;
      mismatches = 0;
    endfunction

    // floor(sqrt(s)) bit by bit over 34 result bits
    function automatic logic [33:0] isqrt68(logic [67:0] s);
      logic [33:0] r;
      logic [33:0] t;
      logic [67:0] p;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
        t = r | (34'd1 << b);
        p = 68'(t) * 68'(t);
        if (p <= s) r = t;
      end
      return r;
    endfunction

    function automatic logic [31:0] quot_sat(logic signed [31:0] x, logic [33:0] nrm);
      logic [32:0] m;
      logic [48:0] q;
      m = x[31] ? 33'(-$signed({x[31], x})) : 33'(x);
      q = ({16'd0, m} << 16) / 49'(nrm);
      if (x[31]) return (q > 49'h80000000) ? 32'h80000000 : 32'(-q);
      return (q > 49'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
    endfunction

    function void note_row(logic signed [7:0] kn, logic signed [7:0] pl,
                           logic signed [31:0] c [7], logic signed [31:0] pen, logic en);
      row_t r;
      logic [67:0] sum;
      logic [32:0] m;
      logic [33:0] nrm;
      logic nz;
      r.status = hsrn_pkg::STATUS_OK; r.knot = '0; r.plane = '0; r.en = 0; r.pen = '0;
      foreach (r.nv[i]) r.nv[i] = '0;
      if (kn < 0 || int'(kn) >= int'(horizon) || kn >= 64 || pl < 0 || pl >= 8) begin
        r.status = hsrn_pkg::STATUS_RANGE;
        pending.push_back(r);
        return;
      end
      r.knot = kn[5:0]; r.plane = pl[2:0];
      sum = '0; nz = 0;
      for (int i = 0; i < 6; i++) begin
        m = c[i][31] ? 33'(-$signed({c[i][31], c[i]})) : 33'(c[i]);
        if (m != 0) nz = 1;
        sum += 68'(m) * 68'(m);
      end
      if (en && nz) begin
        nrm = isqrt68(sum);
        if (nrm != 0) begin
          r.en = 1;
          for (int i = 0; i < 7; i++) r.nv[i] = quot_sat(c[i], nrm);
          r.pen = (pen > 0) ? pen[30:0] : '0;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_row(row_t got);
      row_t e;
      bit bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction knot=%0d", got.knot);
        return;
      end
      e = pending.pop_front();
      bad = (e.status !== got.status) || (e.knot !== got.knot) || (e.plane !== got.plane)
            || (e.en !== got.en) || (e.pen !== got.pen);
      foreach (e.nv[i]) if (e.nv[i] !== got.nv[i]) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp st=%b k=%0d p=%0d en=%b v=%h %h %h %h %h %h %h pen=%h",
                   e.status, e.knot, e.plane, e.en, e.nv[0], e.nv[1], e.nv[2], e.nv[3],
                   e.nv[4], e.nv[5], e.nv[6], e.pen);
          $display("         got st=%b k=%0d p=%0d en=%b v=%h %h %h %h %h %h %h pen=%h",
                   got.status, got.knot, got.plane, got.en, got.nv[0], got.nv[1],
                   got.nv[2], got.nv[3], got.nv[4], got.nv[5], got.nv[6], got.pen);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [6:0] cfg_data = '0;
  logic start = 0;
  logic busy;
  logic signed [7:0] in_knot = '0, in_plane = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic signed [31:0] in_offset = '0, in_penalty = '0;
  logic in_enable = 0;
  logic out_valid, out_status, out_row_enabled;
  logic [5:0] out_row_knot;
  logic [2:0] out_row_plane;
  logic signed [31:0] out_norm_pos_x, out_norm_pos_y, out_norm_pos_z;
  logic signed [31:0] out_norm_vel_x, out_norm_vel_y, out_norm_vel_z, out_norm_offset;
  logic [30:0] out_clamped_penalty;

  halfspace_row_normalizer u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .in_knot(in_knot), .in_plane(in_plane),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_vel_z(in_vel_z),
    .in_offset(in_offset), .in_penalty(in_penalty), .in_enable(in_enable),
    .out_valid(out_valid), .out_status(out_status),
    .out_row_knot(out_row_knot), .out_row_plane(out_row_plane),
    .out_row_enabled(out_row_enabled),
    .out_norm_pos_x(out_norm_pos_x), .out_norm_pos_y(out_norm_pos_y),
    .out_norm_pos_z(out_norm_pos_z), .out_norm_vel_x(out_norm_vel_x),
    .out_norm_vel_y(out_norm_vel_y), .out_norm_vel_z(out_norm_vel_z),
    .out_norm_offset(out_norm_offset), .out_clamped_penalty(out_clamped_penalty)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  row_scoreboard sb = new();
  int cycles = 0;
  int idle_pct = 0;       // chance in 100 that the sender idles in a cycle
  localparam int LATENCY = 72;
  localparam int CYCLE_LIMIT = 400000;

  // sample at the rising edge: accepted inputs feed the predictor, strobes get checked
  always @(posedge clk) begin
    row_t got;
    logic signed [31:0] c [7];
    cycles <= cycles + 1;
    if (rst_n && start && !busy) begin
      c[0] = in_pos_x; c[1] = in_pos_y; c[2] = in_pos_z;
      c[3] = in_vel_x; c[4] = in_vel_y; c[5] = in_vel_z; c[6] = in_offset;
      sb.note_row(in_knot, in_plane, c, in_penalty, in_enable);
    end
    if (rst_n && cfg_valid && cfg_ready) sb.horizon = cfg_data;
    if (rst_n && out_valid) begin
      got.status = out_status; got.knot = out_row_knot; got.plane = out_row_plane;
      got.en = out_row_enabled; got.pen = out_clamped_penalty;
      got.nv[0] = out_norm_pos_x; got.nv[1] = out_norm_pos_y; got.nv[2] = out_norm_pos_z;
      got.nv[3] = out_norm_vel_x; got.nv[4] = out_norm_vel_y; got.nv[5] = out_norm_vel_z;
      got.nv[6] = out_norm_offset;
      sb.check_row(got);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_halfspace_row_normalizer: errors");
      $finish;
    end
  end

  // one input transaction; start stays high across back-to-back rows
  task automatic send_row(logic signed [7:0] kn, logic signed [7:0] pl,
                          logic [31:0] c [7], logic [31:0] pen, logic en);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    in_knot <= kn; in_plane <= pl;
    in_pos_x <= c[0]; in_pos_y <= c[1]; in_pos_z <= c[2];
    in_vel_x <= c[3]; in_vel_y <= c[4]; in_vel_z <= c[5];
    in_offset <= c[6]; in_penalty <= pen; in_enable <= en;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // let the pipeline empty: all expected rows in, then the full latency
  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_horizon(logic [6:0] h);
    cfg_valid <= 1;
    cfg_data <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // random coefficient: mostly full range, some small, some extremes
  function automatic logic [31:0] rnd_coef();
    case ($urandom_range(9))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'd0;
      3, 4: return 32'($signed($urandom_range(8191)) - 4096);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_rows(int n);
    logic [31:0] c [7];
    logic signed [7:0] kn, pl;
    for (int i = 0; i < n; i++) begin
      foreach (c[j]) c[j] = rnd_coef();
      // mostly in-range addresses so rows reach the normalizer
      if ($urandom_range(9) < 8) begin
        kn = 8'($urandom_range(63));
        pl = 8'($urandom_range(7));
      end else begin
        kn = 8'($urandom());
        pl = 8'($urandom());
      end
      // small rows now and then hit tiny norms and overflowing quotients
      if ($urandom_range(7) == 0) begin
        foreach (c[j]) c[j] = 32'($signed($urandom_range(3)) - 1);
        c[6] = $urandom();
      end
      send_row(kn, pl, c, $urandom(), $urandom_range(7) != 0);
    end
  endtask

  initial begin
    logic [31:0] c [7];
    logic [6:0] horizons [6];
    horizons = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd37, 7'd64};
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, disabled, all-zero, bad indices, saturation
    foreach (c[j]) c[j] = 32'h80000000;
    send_row(8'sd0, 8'sd0, c, 32'h80000000, 1);
    foreach (c[j]) c[j] = 32'h7FFFFFFF;
    send_row(8'sd63, 8'sd7, c, 32'h7FFFFFFF, 1);
    send_row(8'sd5, 8'sd2, c, 32'h00010000, 0);
    foreach (c[j]) c[j] = 32'd0;
    c[6] = 32'h12345678;
    send_row(8'sd1, 8'sd1, c, 32'h00020000, 1);
    send_row(8'sd64, 8'sd0, c, 32'd5, 1);
    send_row(-8'sd1, 8'sd0, c, 32'd5, 1);
    send_row(8'sd127, 8'sd8, c, 32'd5, 1);
    send_row(-8'sd128, -8'sd128, c, 32'd5, 1);
    send_row(8'sd3, -8'sd1, c, 32'd5, 1);
    c[0] = 32'd1; c[6] = 32'h80000000;
    send_row(8'sd2, 8'sd3, c, 32'hFFFFFFFF, 1);
    c[6] = 32'h7FFFFFFF;
    send_row(8'sd2, 8'sd4, c, 32'd0, 1);
    c[0] = 32'hFFFFFFFF; c[3] = 32'h00010000; c[6] = 32'hFFFF0000;
    send_row(8'sd10, 8'sd5, c, 32'h40000000, 1);
    drain();

    // phases: horizon setting x sender idling
    foreach (horizons[h]) begin
      write_horizon(horizons[h]);
      idle_pct = (h % 3 == 0) ? 0 : (h % 3 == 1) ? 45 : 10;
      foreach (c[j]) c[j] = 32'h00008000;
      send_row(8'(horizons[h]) - 8'sd1, 8'sd0, c, 32'd1, 1);
      send_row(8'(horizons[h]), 8'sd0, c, 32'd1, 1);
      random_rows(200);
      drain();
    end
    idle_pct = 0;
    random_rows(80);
    drain();

    if (sb.mismatches == 0) begin
      $display("tb_halfspace_row_normalizer: clean");
    end else begin
      $display("tb_halfspace_row_normalizer: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hsrn_pkg.sv
rtl/core/hsrn_sqsum.sv
rtl/core/hsrn_sqrt.sv
rtl/core/hsrn_div.sv
rtl/core/halfspace_row_normalizer.sv
test/tb_halfspace_row_normalizer.sv
